// File: design/bdtcp_pkg.sv
// ----------------------------------------------------------------------------
// BCD day-time clock printer package
// Character codes, message kinds and the fixed console texts.
// ----------------------------------------------------------------------------
package bdtcp_pkg;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   localparam logic       CMD_TICK = 1'b0;
   localparam logic       CMD_RX   = 1'b1;

   localparam int unsigned IDX_W = 5;

   // Index of the final character (LF) for each kind of line.
   localparam logic [IDX_W-1:0] LAST_TICK  = 5'd12;
   localparam logic [IDX_W-1:0] LAST_RESET = 5'd10;
   localparam logic [IDX_W-1:0] LAST_HINT  = 5'd27;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_RESET = 2'd1,
      KIND_HINT  = 2'd2
   } kind_type;

   // "RTC reset" followed by CR and LF.
   function automatic logic [7:0] reset_char(input logic [IDX_W-1:0] idx);
      logic [7:0] ch;
      case (idx)
         5'd0:    ch = "R";
         5'd1:    ch = "T";
         5'd2:    ch = "C";
         5'd3:    ch = " ";
         5'd4:    ch = "r";
         5'd5:    ch = "e";
         5'd6:    ch = "s";
         5'd7:    ch = "e";
         5'd8:    ch = "t";
         5'd9:    ch = CHAR_CR;
         default: ch = CHAR_LF;
      endcase
      return ch;
   endfunction

   // "Press <ENTER> to reset RTC" followed by CR and LF.
   function automatic logic [7:0] hint_char(input logic [IDX_W-1:0] idx);
      logic [7:0] ch;
      case (idx)
         5'd0:    ch = "P";
         5'd1:    ch = "r";
         5'd2:    ch = "e";
         5'd3:    ch = "s";
         5'd4:    ch = "s";
         5'd5:    ch = " ";
         5'd6:    ch = "<";
         5'd7:    ch = "E";
         5'd8:    ch = "N";
         5'd9:    ch = "T";
         5'd10:   ch = "E";
         5'd11:   ch = "R";
         5'd12:   ch = ">";
         5'd13:   ch = " ";
         5'd14:   ch = "t";
         5'd15:   ch = "o";
         5'd16:   ch = " ";
         5'd17:   ch = "r";
         5'd18:   ch = "e";
         5'd19:   ch = "s";
         5'd20:   ch = "e";
         5'd21:   ch = "t";
         5'd22:   ch = " ";
         5'd23:   ch = "R";
         5'd24:   ch = "T";
         5'd25:   ch = "C";
         5'd26:   ch = CHAR_CR;
         default: ch = CHAR_LF;
      endcase
      return ch;
   endfunction

endpackage

// File: design/bcd_day_time_clock_printer.sv
// ----------------------------------------------------------------------------
// BCD day-time clock printer
// Day/hour/minute/second BCD counter with a text console line generator.
// ----------------------------------------------------------------------------
// A tick word (tuser 0) advances the DD:HH:MM:SS count and prints the new
// time as "DD:HH:MM:SS" CR LF; a received byte word (tuser 1) prints
// "RTC reset" CR LF and clears the time when the byte is a carriage return,
// and "Press <ENTER> to reset RTC" CR LF otherwise. Output is one character
// per word, with tlast on the LF. The time is updated in the cycle the input
// word is taken, and a character generator then sends one character per
// cycle unless rsp_tready holds it back; a tick line has 13 characters, a
// reset line 11 and a hint line 28. The next input word is taken in the same
// cycle as the LF of the current line is loaded into the output register.
// ----------------------------------------------------------------------------
module bcd_day_time_clock_printer
   import bdtcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  logic       req_tuser,   // [0] command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast
);

   logic [3:0] sec_u_ff, sec_u_in;
   logic [2:0] sec_t_ff, sec_t_in;
   logic [3:0] min_u_ff, min_u_in;
   logic [2:0] min_t_ff, min_t_in;
   logic [3:0] hr_u_ff,  hr_u_in;
   logic [1:0] hr_t_ff,  hr_t_in;
   logic [3:0] day_u_ff, day_u_in;
   logic [3:0] day_t_ff, day_t_in;

   logic             active_ff, active_in;
   kind_type         kind_ff, kind_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_last_ff, out_last_in;

   logic             accept;
   logic             load;
   logic             last_load;
   logic [IDX_W-1:0] last_idx;
   logic [7:0]       cur_char;
   logic             is_cr;

   assign is_cr     = (req_tdata == CHAR_CR);
   assign load      = active_ff && (!out_valid_ff || rsp_tready);
   assign last_load = load && (idx_ff == last_idx);
   assign req_tready = !active_ff || last_load;
   assign accept    = req_tvalid && req_tready;

   always_comb begin
      case (kind_ff)
         KIND_TICK:  last_idx = LAST_TICK;
         KIND_RESET: last_idx = LAST_RESET;
         default:    last_idx = LAST_HINT;
      endcase
   end

   // Time line characters, taken from the live counters.
   always_comb begin
      case (kind_ff)
         KIND_TICK: begin
            case (idx_ff)
               5'd0:    cur_char = CHAR_ZERO | {4'b0, day_t_ff};
               5'd1:    cur_char = CHAR_ZERO | {4'b0, day_u_ff};
               5'd3:    cur_char = CHAR_ZERO | {6'b0, hr_t_ff};
               5'd4:    cur_char = CHAR_ZERO | {4'b0, hr_u_ff};
               5'd6:    cur_char = CHAR_ZERO | {5'b0, min_t_ff};
               5'd7:    cur_char = CHAR_ZERO | {4'b0, min_u_ff};
               5'd9:    cur_char = CHAR_ZERO | {5'b0, sec_t_ff};
               5'd10:   cur_char = CHAR_ZERO | {4'b0, sec_u_ff};
               5'd11:   cur_char = CHAR_CR;
               5'd12:   cur_char = CHAR_LF;
               default: cur_char = CHAR_COLON;
            endcase
         end
         KIND_RESET: cur_char = reset_char(idx_ff);
         default:    cur_char = hint_char(idx_ff);
      endcase
   end

   // Cascaded BCD count and clear.
   always_comb begin
      sec_u_in = sec_u_ff;
      sec_t_in = sec_t_ff;
      min_u_in = min_u_ff;
      min_t_in = min_t_ff;
      hr_u_in  = hr_u_ff;
      hr_t_in  = hr_t_ff;
      day_u_in = day_u_ff;
      day_t_in = day_t_ff;
      if (accept && req_tuser == CMD_TICK) begin
         if (sec_u_ff != 4'd9) begin
            sec_u_in = sec_u_ff + 4'd1;
         end else begin
            sec_u_in = 4'd0;
            if (sec_t_ff != 3'd5) begin
               sec_t_in = sec_t_ff + 3'd1;
            end else begin
               sec_t_in = 3'd0;
               if (min_u_ff != 4'd9) begin
                  min_u_in = min_u_ff + 4'd1;
               end else begin
                  min_u_in = 4'd0;
                  if (min_t_ff != 3'd5) begin
                     min_t_in = min_t_ff + 3'd1;
                  end else begin
                     min_t_in = 3'd0;
                     if (hr_u_ff == 4'd9) begin
                        hr_u_in = 4'd0;
                        hr_t_in = hr_t_ff + 2'd1;
                     end else if (hr_u_ff == 4'd3 && hr_t_ff == 2'd2) begin
                        // Midnight: the hour wraps and a day is counted.
                        hr_u_in = 4'd0;
                        hr_t_in = 2'd0;
                        if (day_u_ff != 4'd9) begin
                           day_u_in = day_u_ff + 4'd1;
                        end else begin
                           day_u_in = 4'd0;
                           day_t_in = (day_t_ff == 4'd9) ? 4'd0 : day_t_ff + 4'd1;
                        end
                     end else begin
                        hr_u_in = hr_u_ff + 4'd1;
                     end
                  end
               end
            end
         end
      end else if (accept && is_cr) begin
         sec_u_in = 4'd0;
         sec_t_in = 3'd0;
         min_u_in = 4'd0;
         min_t_in = 3'd0;
         hr_u_in  = 4'd0;
         hr_t_in  = 2'd0;
         day_u_in = 4'd0;
         day_t_in = 4'd0;
      end
   end

   always_comb begin
      active_in = active_ff;
      kind_in   = kind_ff;
      idx_in    = idx_ff;
      if (accept) begin
         active_in = 1'b1;
         idx_in    = '0;
         if (req_tuser == CMD_TICK) begin
            kind_in = KIND_TICK;
         end else if (is_cr) begin
            kind_in = KIND_RESET;
         end else begin
            kind_in = KIND_HINT;
         end
      end else if (last_load) begin
         active_in = 1'b0;
      end else if (load) begin
         idx_in = idx_ff + 5'd1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_char_in  = cur_char;
         out_last_in  = (idx_ff == last_idx);
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_u_ff     <= 4'd0;
         sec_t_ff     <= 3'd0;
         min_u_ff     <= 4'd0;
         min_t_ff     <= 3'd0;
         hr_u_ff      <= 4'd0;
         hr_t_ff      <= 2'd0;
         day_u_ff     <= 4'd0;
         day_t_ff     <= 4'd0;
         active_ff    <= 1'b0;
         kind_ff      <= KIND_TICK;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sec_u_ff     <= sec_u_in;
         sec_t_ff     <= sec_t_in;
         min_u_ff     <= min_u_in;
         min_t_ff     <= min_t_in;
         hr_u_ff      <= hr_u_in;
         hr_t_ff      <= hr_t_in;
         day_u_ff     <= day_u_in;
         day_t_ff     <= day_t_in;
         active_ff    <= active_in;
         kind_ff      <= kind_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
